// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and helpers of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int unsigned COLUMNS_DEF = 80;
    localparam int unsigned ROWS_DEF    = 25;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned RROW_W     = 5;
    localparam int unsigned RCOL_W     = 7;
    localparam int unsigned CELL_W     = 16;
    localparam int unsigned ATTR_W     = 8;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'h07;

    typedef logic [2:0] wr_sel_t;

    localparam wr_sel_t WR_NONE   = 3'd0;
    localparam wr_sel_t WR_PUT    = 3'd1;
    localparam wr_sel_t WR_INIT   = 3'd2;
    localparam wr_sel_t WR_FILL   = 3'd3;
    localparam wr_sel_t WR_SCROLL = 3'd4;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clr;
        logic    cnt_inc;
        wr_sel_t wr_sel;
        logic    rd_en;
        logic    rd_scroll;
        logic    cursor_adv;
        logic    cursor_home;
        logic    data_capture;
        logic    out_load;
    } tcw_ctl_t;

    typedef struct packed {
        logic scroll_needed;
        logic fill_end;
        logic scroll_end;
    } tcw_sts_t;

    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] code,
                                                    input logic [ATTR_W-1:0] attr);
        return {attr, code};
    endfunction

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes each word and steps the datapath through the fill,
// put, scroll and read sequences; owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [tcw_pkg::CMD_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire tcw_pkg::tcw_sts_t         sts,
    output tcw_pkg::tcw_ctl_t              ctl
);

    import tcw_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_RDATA  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_INIT: begin
                ctl.wr_sel  = WR_INIT;
                ctl.cnt_inc = 1'b1;
                if (sts.fill_end) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load_item = 1'b1;
                    ctl.cnt_clr   = 1'b1;
                    case (s_tuser)
                        CMD_PUT:   state_next = S_PUT;
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_READ:  state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                ctl.wr_sel     = WR_PUT;
                ctl.cursor_adv = 1'b1;
                state_next     = sts.scroll_needed ? S_SCROLL : S_DONE;
            end
            S_SCROLL: begin
                ctl.wr_sel    = WR_SCROLL;
                ctl.rd_en     = 1'b1;
                ctl.rd_scroll = 1'b1;
                ctl.cnt_inc   = 1'b1;
                if (sts.scroll_end) begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR: begin
                ctl.wr_sel      = WR_FILL;
                ctl.cnt_inc     = 1'b1;
                ctl.cursor_home = 1'b1;
                if (sts.fill_end) begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                ctl.rd_en  = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA: begin
                ctl.data_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen RAM, cursor, colour register, cell counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
    parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tcw_pkg::tcw_ctl_t             ctl,
    output tcw_pkg::tcw_sts_t                  sts,
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
    output logic      [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    import tcw_pkg::*;

    localparam int unsigned CELLS = ROWS * COLUMNS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CW    = $clog2(CELLS + 1);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned LW    = $clog2(COLUMNS);

    logic [CHAR_W-1:0] char_reg;
    logic [RROW_W-1:0] rrow_reg;
    logic [RCOL_W-1:0] rcol_reg;
    logic [ATTR_W-1:0] color_reg;
    logic [RW-1:0]     row_reg, row_next;
    logic [LW-1:0]     col_reg, col_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CELL_W-1:0] data_reg;
    logic [CELL_W-1:0] out_cell_reg;
    logic [RROW_W-1:0] out_row_reg;
    logic [RCOL_W-1:0] out_col_reg;

    logic              newline;
    logic              line_end;
    logic              last_row;
    logic              read_ok;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     rd_cell_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign newline  = (char_reg == NEWLINE_CODE);
    assign line_end = (col_reg == LW'(COLUMNS - 1));
    assign last_row = (row_reg == RW'(ROWS - 1));
    assign read_ok  = (32'(rrow_reg) < 32'(ROWS)) && (32'(rcol_reg) < 32'(COLUMNS));

    assign cur_addr     = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign rd_cell_addr = AW'(rrow_reg) * AW'(COLUMNS) + AW'(rcol_reg);

    assign sts.scroll_needed = (newline || line_end) && last_row;
    assign sts.fill_end      = (idx_reg == CW'(CELLS - 1));
    assign sts.scroll_end    = (idx_reg == CW'(CELLS));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = make_cell(BLANK_CODE, color_reg);
        case (ctl.wr_sel)
            WR_PUT: begin
                ram_we    = !newline;
                ram_waddr = cur_addr;
                ram_wdata = make_cell(char_reg, color_reg);
            end
            WR_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = make_cell(BLANK_CODE, COLOR_RESET);
            end
            WR_FILL: begin
                ram_we = 1'b1;
            end
            WR_SCROLL: begin
                ram_we    = (idx_reg != '0);
                ram_waddr = AW'(idx_reg - CW'(1));
                if (idx_reg <= CW'(CELLS - COLUMNS)) begin
                    ram_wdata = ram_rdata;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = ctl.rd_scroll ? AW'(idx_reg + CW'(COLUMNS)) : rd_cell_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (ctl.cursor_home) begin
            row_next = '0;
            col_next = '0;
        end else if (ctl.cursor_adv) begin
            if (newline || line_end) begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + RW'(1);
                end
            end else begin
                col_next = col_reg + LW'(1);
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (ctl.cnt_clr) begin
            idx_next = '0;
        end else if (ctl.cnt_inc) begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
            color_reg <= COLOR_RESET;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            idx_reg <= idx_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            char_reg <= s_tdata[7:0];
            rrow_reg <= s_tdata[12:8];
            rcol_reg <= s_tdata[19:13];
            data_reg <= '0;
        end else if (ctl.data_capture) begin
            data_reg <= read_ok ? ram_rdata : '0;
        end
        if (ctl.out_load) begin
            out_cell_reg <= data_reg;
            out_row_reg  <= RROW_W'(row_reg);
            out_col_reg  <= RCOL_W'(col_reg);
        end
    end

    assign m_tdata = {4'b0000, out_col_reg, out_row_reg, out_cell_reg};

endmodule

`default_nettype wire

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, line wrap and scroll.
// ----------------------------------------------------------------------------
// Every word on the input gives exactly one result word. A put goes through
// the put and done states, and through the scroll state too when the cursor
// leaves the last row and the screen scrolls; clear goes through the clear
// state, read through the read and read-data states, and an unused command
// straight to done. The screen RAM has one write port, so scroll and clear
// touch one cell per cycle. After reset the block blanks the screen in one
// pass with s_tready low; colour writes are taken during that pass. One word
// is processed at a time; a new word is accepted while the previous result
// still waits on m_tready.
`default_nettype none

module text_console_writer #(
    parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,  // text_color
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13]
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [tcw_pkg::CMD_W-1:0]     s_tuser,      // command[1:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // cell_data[15:0], cursor_row[20:16], cursor_col[27:21]
    output logic      [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    import tcw_pkg::*;

    tcw_ctl_t ctl;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in flight");

    a_result_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[20:16]) < 32'(ROWS))
        else $error("reported cursor row beyond screen");

    a_result_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[27:21]) < 32'(COLUMNS))
        else $error("reported cursor column beyond screen");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !m_tvalid || m_tready)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire

// ===== test/tb_text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking testbench for the text console writer.
// ----------------------------------------------------------------------------
// Words go in on the s_ stream and results come back on the m_ stream. A
// behavioral copy of the screen store, the cursor and the color register
// predicts each result when its word is accepted, and a checker compares
// every result with the oldest prediction. Directed tests cover reset
// contents, put, newline, clear, out-of-range reads, the unused command,
// line wrap and scrolling. A random section follows, run with sender and
// receiver idling in turn, plus a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int unsigned SCREEN_COLS = COLUMNS_DEF;
    localparam int unsigned SCREEN_ROWS = ROWS_DEF;
    localparam int unsigned SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned TAIL_CYCLES = 50;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
    } console_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [CELL_W-1:0] screen_model [0:SCREEN_CELLS-1];
    int unsigned       cursor_row_model;
    int unsigned       cursor_col_model;
    logic [ATTR_W-1:0] color_model;

    console_result_t pending_results[$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned puts_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned clears_sent = 0;
    int unsigned scroll_count = 0;
    int unsigned color_writes = 0;

    text_console_writer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic console_result_t console_step(input logic [CMD_W-1:0]  cmd,
                                                     input logic [CHAR_W-1:0] code,
                                                     input logic [RROW_W-1:0] rrow,
                                                     input logic [RCOL_W-1:0] rcol);
        console_result_t res;
        int unsigned     i;
        res.cell_data = '0;
        case (cmd)
            CMD_PUT: begin
                if (code == NEWLINE_CODE) begin
                    cursor_row_model++;
                    cursor_col_model = 0;
                end else begin
                    screen_model[cursor_row_model * SCREEN_COLS + cursor_col_model] =
                        {color_model, code};
                    cursor_col_model++;
                    if (cursor_col_model >= SCREEN_COLS) begin
                        cursor_col_model = 0;
                        cursor_row_model++;
                    end
                end
                if (cursor_row_model >= SCREEN_ROWS) begin
                    cursor_row_model = SCREEN_ROWS - 1;
                    cursor_col_model = 0;
                    for (i = 0; i + SCREEN_COLS < SCREEN_CELLS; i++)
                        screen_model[i] = screen_model[i + SCREEN_COLS];
                    for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                        screen_model[i] = {color_model, BLANK_CODE};
                    scroll_count++;
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < SCREEN_CELLS; i++)
                    screen_model[i] = {color_model, BLANK_CODE};
                cursor_row_model = 0;
                cursor_col_model = 0;
            end
            CMD_READ: begin
                if (rrow < SCREEN_ROWS && rcol < SCREEN_COLS)
                    res.cell_data = screen_model[rrow * SCREEN_COLS + rcol];
            end
            default: ;
        endcase
        res.row = cursor_row_model[RROW_W-1:0];
        res.col = cursor_col_model[RCOL_W-1:0];
        return res;
    endfunction

    // Check each result word and drive the receiver side.
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cell_data = m_tdata[15:0];
            got.row       = m_tdata[20:16];
            got.col       = m_tdata[27:21];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result word: actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.cell_data !== want.cell_data) begin
                    $display("%0t cell_data mismatch: expected %h actual %h",
                             $time, want.cell_data, got.cell_data);
                    error_count++;
                end
                if (got.row !== want.row) begin
                    $display("%0t cursor_row mismatch: expected %0d actual %0d",
                             $time, want.row, got.row);
                    error_count++;
                end
                if (got.col !== want.col) begin
                    $display("%0t cursor_col mismatch: expected %0d actual %0d",
                             $time, want.col, got.col);
                    error_count++;
                end
            end
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_request != 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    task automatic send_word(input logic [CMD_W-1:0]  cmd,
                             input logic [CHAR_W-1:0] code,
                             input logic [RROW_W-1:0] rrow,
                             input logic [RCOL_W-1:0] rcol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, rcol, rrow, code};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(console_step(cmd, code, rrow, rcol));
        words_sent++;
        case (cmd)
            CMD_PUT:   puts_sent++;
            CMD_CLEAR: clears_sent++;
            CMD_READ:  reads_sent++;
            default: ;
        endcase
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_word(CMD_PUT, code, RROW_W'($urandom), RCOL_W'($urandom));
    endtask

    task automatic read_cell(input int unsigned rrow, input int unsigned rcol);
        send_word(CMD_READ, CHAR_W'($urandom), RROW_W'(rrow), RCOL_W'(rcol));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_text_color(input logic [ATTR_W-1:0] color);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        color_model = color;
        color_writes++;
    endtask

    task automatic put_printable();
        logic [CHAR_W-1:0] code;
        code = CHAR_W'($urandom);
        if (code == NEWLINE_CODE)
            code = BLANK_CODE;
        put_char(code);
    endtask

    task automatic test_reset_screen();
        read_cell(0, 0);
        read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        read_cell(12, 40);
        read_cell(SCREEN_ROWS, 0);
        read_cell(0, SCREEN_COLS);
        read_cell('1, '1);
        send_word(CMD_UNUSED, '1, '1, '1);
        send_word(CMD_UNUSED, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_put_and_newline();
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(NEWLINE_CODE);
        put_char(8'h5A);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(0, 3);
        read_cell(1, 0);
        read_cell(2, 0);
        wait_drained();
    endtask

    task automatic test_clear_screen();
        write_text_color(8'hFF);
        send_word(CMD_CLEAR, '1, '1, '1);
        read_cell(0, 0);
        read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        write_text_color(8'h00);
        put_char(8'h7E);
        read_cell(0, 0);
        send_word(CMD_CLEAR, '0, '0, '0);
        read_cell(0, 0);
        wait_drained();
    endtask

    task automatic test_line_wrap();
        write_text_color(8'h1F);
        send_word(CMD_CLEAR, '0, '0, '0);
        repeat (SCREEN_COLS) put_printable();
        read_cell(0, SCREEN_COLS - 1);
        read_cell(1, 0);
        repeat (3) put_printable();
        read_cell(1, 2);
        read_cell(1, 3);
        wait_drained();
    endtask

    task automatic test_scroll();
        write_text_color(8'h4E);
        send_word(CMD_CLEAR, '0, '0, '0);
        put_char(8'h58);
        repeat (SCREEN_ROWS - 1) put_char(NEWLINE_CODE);
        repeat (5) put_printable();
        read_cell(SCREEN_ROWS - 1, 4);
        put_char(NEWLINE_CODE);
        read_cell(SCREEN_ROWS - 2, 0);
        read_cell(SCREEN_ROWS - 1, 0);
        read_cell(0, 0);
        write_text_color(8'hA3);
        repeat (SCREEN_COLS) put_printable();
        read_cell(SCREEN_ROWS - 2, SCREEN_COLS - 1);
        read_cell(SCREEN_ROWS - 1, 0);
        read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_request = 600;
        @(posedge aclk);
        repeat (4) put_printable();
        repeat (4) read_cell(cursor_row_model, $urandom_range(0, 79));
        wait_drained();
    endtask

    task automatic random_words(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned run_len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                      : $urandom_range(1, 12);
                repeat (run_len) put_printable();
                sent += run_len;
                if ($urandom_range(0, 99) < 60) begin
                    put_char(NEWLINE_CODE);
                    sent++;
                end
            end else if (pick < 80) begin
                if ($urandom_range(0, 99) < 70)
                    read_cell(cursor_row_model - $urandom_range(0, 1),
                              $urandom_range(0, SCREEN_COLS - 1));
                else
                    read_cell($urandom, $urandom);
                sent++;
            end else if (pick < 83) begin
                send_word(CMD_CLEAR, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
                sent++;
            end else if (pick < 90) begin
                send_word(CMD_UNUSED, CHAR_W'($urandom), RROW_W'($urandom),
                          RCOL_W'($urandom));
            end else begin
                put_char(CHAR_W'($urandom));
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 16;
        rcv_stall_pct = 45;
        random_words(20);
        write_text_color(CHAR_W'($urandom));
        send_idle_pct = 45;
        rcv_stall_pct = 16;
        random_words(20);
        write_text_color(8'hFF);
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        random_words(20);
    endtask

    initial begin
        int unsigned i;
        for (i = 0; i < SCREEN_CELLS; i++)
            screen_model[i] = {COLOR_RESET, BLANK_CODE};
        cursor_row_model = 0;
        cursor_col_model = 0;
        color_model = COLOR_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 16;
        rcv_stall_pct = 45;
        test_reset_screen();
        test_put_and_newline();
        test_clear_screen();
        test_line_wrap();
        test_scroll();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d words (%0d puts, %0d reads, %0d clears), checked %0d results;",
                 words_sent, puts_sent, reads_sent, clears_sent, results_checked);
        $display("saw %0d scrolls across %0d color settings, in %0d cycles.",
                 scroll_count, color_writes + 1, cycle_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
